### hw/rtl/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
`default_nettype none

package stt_pkg;

	// Token slots in one bundle: at most three tokens follow from one input beat.
	localparam int TOK_SLOTS = 3;
	localparam int SLOT_W = 2;

	// Bundles held between the scanner and the output serializer.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		TOK_EOF     = 4'd0,
		TOK_LET     = 4'd1,
		TOK_IDENT   = 4'd2,
		TOK_NUMBER  = 4'd3,
		TOK_ASSIGN  = 4'd4,
		TOK_PLUS    = 4'd5,
		TOK_MINUS   = 4'd6,
		TOK_STAR    = 4'd7,
		TOK_SLASH   = 4'd8,
		TOK_MODULO  = 4'd9,
		TOK_CARET   = 4'd10,
		TOK_LPAREN  = 4'd11,
		TOK_RPAREN  = 4'd12,
		TOK_UNKNOWN = 4'd13
	} tok_type_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_IDENT = 3'd1,
		MODE_INT   = 3'd2,
		MODE_DOT   = 3'd3,
		MODE_FRAC  = 3'd4
	} scan_mode_t;

	typedef enum logic [2:0] {
		KW_NONE = 3'd0,
		KW_L    = 3'd1,
		KW_LE   = 3'd2,
		KW_LET  = 3'd3,
		KW_MISS = 3'd4
	} kw_t;

	typedef struct packed {
		tok_type_t   ttype;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
	} token_t;

	typedef struct packed {
		logic [SLOT_W-1:0]        count;
		token_t [TOK_SLOTS-1:0]   tok;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

### hw/rtl/source_text_tokenizer_unit.sv
// A token reaches the master side through the bundle queue, which registers each bundle the scanner builds.
// Throughput: one source beat per cycle while the queue is not full; each token takes one output beat, so a
// beat that yields several tokens (up to three) holds the output while its tokens are sent, absorbed by a
// four-bundle queue between the scanner and the serializer.
// Reset: arst_n clears scan state (position 0, line 1) and empties the queue at once.
`default_nettype none

module source_text_tokenizer_unit #(
	parameter longint unsigned MAX_POSITION = 65535,
	parameter longint unsigned MAX_LINE     = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tuser,   // [0] kind (1 = end of input)
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] token_start, [31:16] token_length,
	                                    // [47:32] line_number
	output logic [3:0]       m_tuser,   // [3:0] token_type
	output logic             m_tlast    // last token of the bundle
);
	import stt_pkg::*;

	q_stat_t q_stat;
	bundle_t push_data;
	bundle_t head;
	logic    push;
	logic    pop;

	// Scanner front end.
	stt_front #(
		.MAX_POSITION(MAX_POSITION),
		.MAX_LINE    (MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.kind     (s_tuser),
		.char_code(s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data)
	);

	// Bundle queue.
	stt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// Output serializer.
	stt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

### hw/rtl/stt_front.sv
// Scanner front end: accepts source beats, tracks scan state, builds token bundles.
`default_nettype none

module stt_front #(
	parameter longint unsigned MAX_POSITION = 65535,
	parameter longint unsigned MAX_LINE     = 65535
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            kind,
	input  wire logic [7:0]      char_code,
	input  wire stt_pkg::q_stat_t q_stat,
	output logic                 push,
	output stt_pkg::bundle_t     push_data
);
	import stt_pkg::*;

	localparam int POS_W  = $clog2(MAX_POSITION + 1);
	localparam int LINE_W = $clog2(MAX_LINE + 1);
	localparam logic [POS_W-1:0]  POS_LIM  = POS_W'(MAX_POSITION);
	localparam logic [LINE_W-1:0] LINE_LIM = LINE_W'(MAX_LINE);

	localparam logic [7:0] CH_L          = 8'h6C;
	localparam logic [7:0] CH_E          = 8'h65;
	localparam logic [7:0] CH_T          = 8'h74;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_ASSIGN     = 8'h3D;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDERSCORE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic tok_type_t op_type(input logic [7:0] c);
		tok_type_t t;
		unique case (c)
			CH_ASSIGN:  t = TOK_ASSIGN;
			CH_PLUS:    t = TOK_PLUS;
			CH_MINUS:   t = TOK_MINUS;
			CH_STAR:    t = TOK_STAR;
			CH_SLASH:   t = TOK_SLASH;
			CH_PERCENT: t = TOK_MODULO;
			CH_CARET:   t = TOK_CARET;
			CH_LPAREN:  t = TOK_LPAREN;
			CH_RPAREN:  t = TOK_RPAREN;
			default:    t = TOK_UNKNOWN;
		endcase
		return t;
	endfunction

	function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
		return (v < POS_LIM) ? v + 1'b1 : POS_LIM;
	endfunction

	function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] v);
		return (v < LINE_LIM) ? v + 1'b1 : LINE_LIM;
	endfunction

	function automatic logic [15:0] clamp16(input logic [31:0] v);
		return (v > 32'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic token_t mk_tok(input tok_type_t t, input logic [31:0] st,
	                                  input logic [31:0] len, input logic [31:0] ln);
		token_t r;
		r.ttype  = t;
		r.start  = clamp16(st);
		r.length = clamp16(len);
		r.line   = clamp16(ln);
		return r;
	endfunction

	scan_mode_t        mode_q, mode_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [POS_W-1:0]  start_q, start_d;
	logic [LINE_W-1:0] line_q, line_d;
	kw_t               kw_q, kw_d;

	logic [POS_W-1:0]        pend_len;
	logic [SLOT_W-1:0]       n_v;
	token_t [TOK_SLOTS-1:0]  tok_v;
	logic                    do_flush;
	logic                    do_fresh;
	logic                    accept;

	// The queue decides whether a new beat can enter.
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// Scan state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			line_q  <= LINE_W'(1);
			kw_q    <= KW_NONE;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			line_q  <= line_d;
			kw_q    <= kw_d;
		end
	end

	// Next scan state and the tokens this beat produces, in the order they appear.
	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		start_d  = start_q;
		line_d   = line_q;
		kw_d     = kw_q;
		n_v      = '0;
		tok_v    = '0;
		do_flush = 1'b0;
		do_fresh = 1'b0;
		pend_len = '0;

		// Decide whether the byte extends the pending token or ends it.
		if (kind) begin
			do_flush = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_letter(char_code) || is_digit(char_code)) begin
						if (kw_q == KW_L && char_code == CH_E) begin
							kw_d = KW_LE;
						end else if (kw_q == KW_LE && char_code == CH_T) begin
							kw_d = KW_LET;
						end else begin
							kw_d = KW_MISS;
						end
						pos_d = pos_inc(pos_q);
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				MODE_INT: begin
					if (is_digit(char_code)) begin
						pos_d = pos_inc(pos_q);
					end else if (char_code == CH_DOT) begin
						// The dot is held without consuming it until the next byte.
						mode_d = MODE_DOT;
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				MODE_DOT: begin
					if (is_digit(char_code)) begin
						pos_d  = pos_inc(pos_inc(pos_q));
						mode_d = MODE_FRAC;
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (is_digit(char_code)) begin
						pos_d = pos_inc(pos_q);
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				default: begin
					mode_d   = MODE_IDLE;
					do_fresh = 1'b1;
				end
			endcase
		end

		// Emit the pending token, and a held dot as an unknown token after it.
		if (do_flush) begin
			pend_len = pos_d - start_d;
			unique case (mode_d)
				MODE_IDENT: begin
					tok_v[n_v] = mk_tok((kw_d == KW_LET) ? TOK_LET : TOK_IDENT,
					                    32'(start_d), 32'(pend_len), 32'(line_d));
					n_v = n_v + 1'b1;
				end
				MODE_INT, MODE_FRAC: begin
					tok_v[n_v] = mk_tok(TOK_NUMBER, 32'(start_d), 32'(pend_len), 32'(line_d));
					n_v = n_v + 1'b1;
				end
				MODE_DOT: begin
					tok_v[n_v] = mk_tok(TOK_NUMBER, 32'(start_d), 32'(pend_len), 32'(line_d));
					n_v = n_v + 1'b1;
					tok_v[n_v] = mk_tok(TOK_UNKNOWN, 32'(pos_d), 32'd1, 32'(line_d));
					n_v = n_v + 1'b1;
					pos_d = pos_inc(pos_d);
				end
				default: begin
				end
			endcase
			mode_d = MODE_IDLE;
			kw_d   = KW_NONE;
		end

		// Handle the byte as the first byte after a token boundary.
		if (do_fresh) begin
			if (is_space(char_code)) begin
				if (char_code == CH_LF) begin
					line_d = line_inc(line_d);
				end
			end else if (is_letter(char_code)) begin
				mode_d  = MODE_IDENT;
				start_d = pos_d;
				kw_d    = (char_code == CH_L) ? KW_L : KW_MISS;
			end else if (is_digit(char_code)) begin
				mode_d  = MODE_INT;
				start_d = pos_d;
			end else begin
				start_d    = pos_d;
				tok_v[n_v] = mk_tok(op_type(char_code), 32'(pos_d), 32'd1, 32'(line_d));
				n_v = n_v + 1'b1;
			end
			pos_d = pos_inc(pos_d);
		end

		// End of input: close the run with an end-of-file token and start over.
		if (kind) begin
			tok_v[n_v] = mk_tok(TOK_EOF, 32'(pos_d), 32'd0, 32'(line_d));
			n_v = n_v + 1'b1;
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			start_d = '0;
			line_d  = LINE_W'(1);
			kw_d    = KW_NONE;
		end
	end

	// Only beats that produce tokens enter the queue.
	assign push            = accept && (n_v != '0);
	assign push_data.count = n_v;
	assign push_data.tok   = tok_v;

endmodule

`default_nettype wire

### hw/rtl/stt_queue.sv
// Short bundle queue between the scanner and the output serializer.
`default_nettype none

module stt_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire stt_pkg::bundle_t  push_data,
	input  wire logic              pop,
	output stt_pkg::bundle_t       head,
	output stt_pkg::q_stat_t       stat
);
	import stt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/stt_back.sv
// Output serializer: sends the tokens of each bundle one beat at a time.
`default_nettype none

module stt_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stt_pkg::bundle_t  head,
	input  wire stt_pkg::q_stat_t  q_stat,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [47:0]            m_tdata,
	output logic [3:0]             m_tuser,
	output logic                   m_tlast
);
	import stt_pkg::*;

	logic [SLOT_W-1:0] idx_q;
	token_t            tok;
	logic              beat;

	// Present the current slot of the head bundle.
	assign tok      = head.tok[idx_q];
	assign m_tvalid = !q_stat.empty;
	assign m_tdata  = {tok.line, tok.length, tok.start};
	assign m_tuser  = tok.ttype;
	assign m_tlast  = (idx_q == head.count - 1'b1);
	assign beat     = m_tvalid && m_tready;
	assign pop      = beat && m_tlast;

	// Slot index within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (beat) begin
			idx_q <= m_tlast ? '0 : idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire
